### rtl/paed_pkg.sv
// shared constants and types for the pwm absolute encoder decoder
`default_nettype none
package paed_pkg;
    localparam int VOTE_DEPTH_DEF = 8;
    localparam int TIME_BITS_DEF  = 32;
    localparam int READ_W   = 13;
    localparam int POS_W    = 12;
    localparam int LAP_W    = 32;
    localparam int DIR_W    = 2;
    localparam int CNT_W    = 7;
    localparam int IN_TIME_W = 32;
    localparam int PHASE_W  = 13;

    localparam logic [PHASE_W-1:0] WIN_PHASE_MAX  = 13'd4302;
    localparam logic [PHASE_W-1:0] WIN_PERIOD_MIN = 13'd3731;
    localparam logic [PHASE_W-1:0] WIN_PERIOD_MAX = 13'd4545;
    localparam logic [PHASE_W-1:0] SCALE_NUM      = 13'd4098;
    localparam logic [READ_W-1:0]  POS_DIRECT_MAX = 13'd4094;
    localparam logic [READ_W-1:0]  POS_WRAP_A     = 13'd4096;
    localparam logic [READ_W-1:0]  POS_WRAP_B     = 13'd4097;
    localparam logic [POS_W-1:0]   POS_TOP        = 12'd4095;
    localparam int LAP_JUMP     = 1000;
    localparam int DIR_DEADBAND = 2;

    localparam logic [DIR_W-1:0] DIR_UNKNOWN = 2'd0;
    localparam logic [DIR_W-1:0] DIR_CW      = 2'd1;
    localparam logic [DIR_W-1:0] DIR_CCW     = 2'd2;

    // measured frame handed from front to back
    typedef struct packed {
        logic [PHASE_W-1:0] hight;
        logic [PHASE_W-1:0] period;
    } frame_t;

    typedef struct packed {
        logic [POS_W-1:0] position;
        logic [LAP_W-1:0] lap_count;
        logic [DIR_W-1:0] turn_direction;
        logic [CNT_W-1:0] vote_count;
    } result_t;
endpackage
`default_nettype wire

### rtl/paed_if.sv
// valid/ready channel interfaces for edges and results
`default_nettype none
interface paed_edge_if;
    logic        valid;
    logic        ready;
    logic        level;
    logic [31:0] time_us;
    modport source (output valid, output level, output time_us, input ready);
    modport sink   (input valid, input level, input time_us, output ready);
endinterface

interface paed_result_if;
    logic        valid;
    logic        ready;
    logic [11:0] position;
    logic signed [31:0] lap_count;
    logic [1:0]  turn_direction;
    logic [6:0]  vote_count;
    modport source (output valid, output position, output lap_count,
                    output turn_direction, output vote_count, input ready);
    modport sink   (input valid, input position, input lap_count,
                    input turn_direction, input vote_count, output ready);
endinterface
`default_nettype wire

### rtl/paed_front.sv
// edge front end: timing, window checks, frame queue push
`default_nettype none
module paed_front
    import paed_pkg::*;
#(
    parameter int TIME_BITS = TIME_BITS_DEF
)(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          enable,
    input  wire logic          in_valid,
    output logic               in_ready,
    input  wire logic          level,
    input  wire logic [IN_TIME_W-1:0] time_us,
    output logic               frame_valid,
    input  wire logic          frame_ready,
    output frame_t             frame
);
    localparam int TW = TIME_BITS;

    logic [TW-1:0] low_start_reg, low_start_next;
    logic [TW-1:0] prev_rise_reg, prev_rise_next;
    logic          rise_valid_reg, rise_valid_next;
    logic          q_valid_reg, q_valid_next;
    frame_t        q_reg, q_next;
    logic [TW-1:0] t, lowt, period, hight;
    logic          win_ok, accept;

    // hold new edges while the one-entry frame queue is occupied
    assign in_ready    = !q_valid_reg;
    assign accept      = in_valid && in_ready;
    assign frame_valid = q_valid_reg;
    assign frame       = q_reg;

    // interval measurement modulo the timer width
    always_comb
    begin
        t      = TW'(time_us);
        lowt   = t - low_start_reg;
        period = t - prev_rise_reg;
        hight  = period - lowt;
        win_ok = (hight >= TW'(1)) && (hight <= TW'(WIN_PHASE_MAX))
              && (lowt >= TW'(1)) && (lowt <= TW'(WIN_PHASE_MAX))
              && (period >= TW'(WIN_PERIOD_MIN)) && (period <= TW'(WIN_PERIOD_MAX));
    end

    // edge state and queue update
    always_comb
    begin
        low_start_next  = low_start_reg;
        prev_rise_next  = prev_rise_reg;
        rise_valid_next = rise_valid_reg;
        q_valid_next    = q_valid_reg && !frame_ready;
        q_next          = q_reg;
        if (accept && enable)
        begin
            if (!level)
                low_start_next = t;
            else
            begin
                prev_rise_next  = t;
                rise_valid_next = 1'b1;
                if (rise_valid_reg && win_ok)
                begin
                    q_valid_next = 1'b1;
                    q_next.hight  = hight[PHASE_W-1:0];
                    q_next.period = period[PHASE_W-1:0];
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            low_start_reg  <= '0;
            prev_rise_reg  <= '0;
            rise_valid_reg <= 1'b0;
            q_valid_reg    <= 1'b0;
        end
        else
        begin
            low_start_reg  <= low_start_next;
            prev_rise_reg  <= prev_rise_next;
            rise_valid_reg <= rise_valid_next;
            q_valid_reg    <= q_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg <= q_next;
    end
endmodule
`default_nettype wire

### rtl/paed_back.sv
// back end: serial divide, ring vote, position mapping and lap tracking
`default_nettype none
module paed_back
    import paed_pkg::*;
#(
    parameter int VOTE_DEPTH = VOTE_DEPTH_DEF
)(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic frame_valid,
    output logic      frame_ready,
    input  wire frame_t frame,
    output logic      res_valid,
    input  wire logic res_ready,
    output result_t   res
);
    localparam int IW  = (VOTE_DEPTH > 1) ? $clog2(VOTE_DEPTH) : 1;
    localparam int QW  = 13;
    localparam int NW  = 26;
    localparam int DIVSTEPS = NW;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_DIV  = 3'd1;
    localparam logic [2:0] S_STORE = 3'd2;
    localparam logic [2:0] S_VOTE = 3'd3;
    localparam logic [2:0] S_MAP  = 3'd4;

    logic [2:0]  state_reg, state_next;
    logic [NW-1:0] num_reg, num_next;
    logic [PHASE_W-1:0] rem_reg, rem_next;
    logic [PHASE_W-1:0] div_reg, div_next;
    logic [4:0]  step_reg, step_next;
    logic [READ_W-1:0] ring_reg [VOTE_DEPTH];
    logic [READ_W-1:0] reading;
    logic [IW-1:0] widx_reg, widx_next;
    logic        full_reg, full_next;
    logic [IW-1:0] vi_reg, vi_next;
    logic [READ_W-1:0] best_reg, best_next;
    logic [CNT_W-1:0]  bestn_reg, bestn_next;
    logic [CNT_W-1:0]  n_cur;
    logic [POS_W-1:0]  last_reg, last_next;
    logic        started_reg, started_next;
    logic [LAP_W-1:0] lap_reg, lap_next;
    logic [DIR_W-1:0] dir_reg, dir_next;
    logic        ovalid_reg, ovalid_next;
    result_t     res_reg, res_next;
    logic [PHASE_W:0] trial;
    logic        map_ok;
    logic [POS_W-1:0] pos;
    logic signed [POS_W:0] delta;
    logic        store_en;

    assign frame_ready = (state_reg == S_IDLE);
    assign res_valid   = ovalid_reg;
    assign res         = res_reg;
    assign reading     = num_reg[QW-1:0] - QW'(1);

    // count ring matches for the current candidate
    always_comb
    begin
        n_cur = '0;
        for (int j = 0; j < VOTE_DEPTH; j++)
            n_cur = n_cur + CNT_W'(ring_reg[j] == ring_reg[vi_reg]);
    end

    // map voted reading and compute position difference
    always_comb
    begin
        map_ok = 1'b1;
        pos    = best_reg[POS_W-1:0];
        if (best_reg <= POS_DIRECT_MAX)
            pos = best_reg[POS_W-1:0];
        else if (best_reg == POS_WRAP_A || best_reg == POS_WRAP_B)
            pos = POS_TOP;
        else
            map_ok = 1'b0;
        delta = $signed({1'b0, pos}) - $signed({1'b0, last_reg});
    end

    always_comb
    begin
        trial = {rem_reg, num_reg[NW-1]} - {1'b0, div_reg};
    end

    // sequencer
    always_comb
    begin
        state_next   = state_reg;
        num_next     = num_reg;
        rem_next     = rem_reg;
        div_next     = div_reg;
        step_next    = step_reg;
        widx_next    = widx_reg;
        full_next    = full_reg;
        vi_next      = vi_reg;
        best_next    = best_reg;
        bestn_next   = bestn_reg;
        last_next    = last_reg;
        started_next = started_reg;
        lap_next     = lap_reg;
        dir_next     = dir_reg;
        ovalid_next  = ovalid_reg && !res_ready;
        res_next     = res_reg;
        store_en     = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (frame_valid)
                begin
                    num_next   = NW'(frame.hight) * NW'(SCALE_NUM);
                    div_next   = frame.period;
                    rem_next   = '0;
                    step_next  = '0;
                    state_next = S_DIV;
                end
            end
            // restoring division, one quotient bit a cycle
            S_DIV:
            begin
                if (!trial[PHASE_W])
                begin
                    rem_next = trial[PHASE_W-1:0];
                    num_next = {num_reg[NW-2:0], 1'b1};
                end
                else
                begin
                    rem_next = {rem_reg[PHASE_W-2:0], num_reg[NW-1]};
                    num_next = {num_reg[NW-2:0], 1'b0};
                end
                step_next = step_reg + 5'd1;
                if (step_reg == 5'(DIVSTEPS-1))
                    state_next = S_STORE;
            end
            S_STORE:
            begin
                store_en = 1'b1;
                if (widx_reg == IW'(VOTE_DEPTH-1))
                begin
                    widx_next = '0;
                    full_next = 1'b1;
                end
                else
                    widx_next = widx_reg + IW'(1);
                vi_next    = '0;
                bestn_next = '0;
                best_next  = '0;
                if (full_reg || widx_reg == IW'(VOTE_DEPTH-1))
                    state_next = S_VOTE;
                else
                    state_next = S_IDLE;
            end
            // one candidate per cycle
            S_VOTE:
            begin
                if (n_cur > bestn_reg || (n_cur == bestn_reg && ring_reg[vi_reg] < best_reg))
                begin
                    bestn_next = n_cur;
                    best_next  = ring_reg[vi_reg];
                end
                vi_next = vi_reg + IW'(1);
                if (vi_reg == IW'(VOTE_DEPTH-1))
                    state_next = S_MAP;
            end
            S_MAP:
            begin
                if (!ovalid_reg || res_ready)
                begin
                    state_next = S_IDLE;
                    if (map_ok)
                    begin
                        started_next = 1'b1;
                        last_next    = pos;
                        if (started_reg)
                        begin
                            priority if (delta > (POS_W+1)'(LAP_JUMP))
                            begin
                                lap_next = lap_reg - LAP_W'(1);
                                dir_next = DIR_CW;
                            end
                            else if (delta < -(POS_W+1)'(LAP_JUMP))
                            begin
                                lap_next = lap_reg + LAP_W'(1);
                                dir_next = DIR_CCW;
                            end
                            else if (delta > (POS_W+1)'(DIR_DEADBAND))
                                dir_next = DIR_CW;
                            else if (delta < -(POS_W+1)'(DIR_DEADBAND))
                                dir_next = DIR_CCW;
                            else
                                dir_next = dir_reg;
                            ovalid_next = 1'b1;
                            res_next.position   = pos;
                            res_next.lap_count  = lap_next;
                            res_next.turn_direction = dir_next;
                            res_next.vote_count = bestn_reg;
                        end
                    end
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // vote ring storage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < VOTE_DEPTH; i++)
                ring_reg[i] <= '0;
        end
        else if (store_en)
            ring_reg[widx_reg] <= reading;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            step_reg    <= '0;
            widx_reg    <= '0;
            full_reg    <= 1'b0;
            vi_reg      <= '0;
            last_reg    <= '0;
            started_reg <= 1'b0;
            lap_reg     <= '0;
            dir_reg     <= DIR_UNKNOWN;
            ovalid_reg  <= 1'b0;
            bestn_reg   <= '0;
            best_reg    <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            step_reg    <= step_next;
            widx_reg    <= widx_next;
            full_reg    <= full_next;
            vi_reg      <= vi_next;
            last_reg    <= last_next;
            started_reg <= started_next;
            lap_reg     <= lap_next;
            dir_reg     <= dir_next;
            ovalid_reg  <= ovalid_next;
            bestn_reg   <= bestn_next;
            best_reg    <= best_next;
        end
    end

    always_ff @(posedge clk)
    begin
        num_reg <= num_next;
        rem_reg <= rem_next;
        div_reg <= div_next;
        res_reg <= res_next;
    end
endmodule
`default_nettype wire

### rtl/pwm_absolute_encoder_decoder_core.sv
// top level of the pwm absolute encoder decoder
//
//  channel   | dir | payload                                        | handshake
//  edge_in   | in  | level, time_us                                 | valid/ready
//  result    | out | position, lap_count, turn_direction, vote_count | valid/ready
//  enable    | in  | enable_data                                    | enable_we
//
// a falling edge only records its time stamp; a rising edge that yields a frame
// is registered in the frame queue, then passes the serial divider, a store step
// and, once the ring is full, a vote over the VOTE_DEPTH ring entries and a
// mapping step. the vote takes one candidate per cycle. reset is asynchronous
// and clears the control state; the ring resets to zero, data registers are not reset.
// a stalled result holds the mapping step; new edges wait while the queue is full.
`default_nettype none
module pwm_absolute_encoder_decoder_core
    import paed_pkg::*;
#(
    parameter int VOTE_DEPTH = VOTE_DEPTH_DEF,
    parameter int TIME_BITS  = TIME_BITS_DEF
)(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     enable_we,
    input  wire logic     enable_data,
    paed_edge_if.sink     edge_in,
    paed_result_if.source result
);
    logic   enable_reg;
    logic   frame_valid, frame_ready;
    frame_t frame;
    result_t res;

    // enable register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            enable_reg <= 1'b0;
        else if (enable_we)
            enable_reg <= enable_data;
    end

    paed_front #(.TIME_BITS(TIME_BITS)) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .enable      (enable_reg),
        .in_valid    (edge_in.valid),
        .in_ready    (edge_in.ready),
        .level       (edge_in.level),
        .time_us     (edge_in.time_us),
        .frame_valid (frame_valid),
        .frame_ready (frame_ready),
        .frame       (frame)
    );

    paed_back #(.VOTE_DEPTH(VOTE_DEPTH)) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .frame_valid (frame_valid),
        .frame_ready (frame_ready),
        .frame       (frame),
        .res_valid   (result.valid),
        .res_ready   (result.ready),
        .res         (res)
    );

    assign result.position       = res.position;
    assign result.lap_count      = res.lap_count;
    assign result.turn_direction = res.turn_direction;
    assign result.vote_count     = res.vote_count;
endmodule
`default_nettype wire

### tb/tb_top.sv
// self-checking testbench for the pwm absolute encoder decoder core
`timescale 1ns / 100ps
module tb_top;
    import paed_pkg::*;

    localparam int RING_DEPTH   = 8;
    localparam int SETTLE_CYC   = 100;
    localparam int HOLD_CYC     = 2000;
    localparam int RAND_FRAMES  = 320;

    logic clk;
    logic rst_n;
    logic enable_we;
    logic enable_data;

    paed_edge_if   edge_if ();
    paed_result_if res_if ();

    pwm_absolute_encoder_decoder_core uut (
        .clk         (clk),
        .rst_n       (rst_n),
        .enable_we   (enable_we),
        .enable_data (enable_data),
        .edge_in     (edge_if),
        .result      (res_if)
    );

    // clock, 12 ns period
    always
    begin
        clk = 1'b1;
        #6;
        clk = 1'b0;
        #6;
    end

    // decoder copy kept by the testbench
    logic                en_shadow;
    logic [31:0]         fall_stamp;
    logic [31:0]         rise_stamp;
    logic                rise_seen;
    logic [READ_W-1:0]   readings [RING_DEPTH];
    int unsigned         wr_slot;
    logic                readings_full;
    logic [POS_W-1:0]    prev_pos;
    logic                pos_seeded;
    logic [LAP_W-1:0]    laps;
    logic [DIR_W-1:0]    heading;

    result_t     pending_q [$];
    logic        failed = 1'b0;
    int unsigned results_seen = 0;
    logic        hold_rx;
    logic [31:0] t_now;

    // predict one edge; returns 1 when a result is due
    function automatic logic decode_edge(input logic lvl, input logic [31:0] t,
                                         output result_t res);
        logic [31:0] lowt, per, hight;
        logic [63:0] prod;
        logic [READ_W-1:0] rd, best;
        int unsigned n, best_n;
        logic [POS_W-1:0] pos;
        int signed delta;
        res = '0;
        if (!en_shadow)
            return 1'b0;
        if (!lvl)
        begin
            fall_stamp = t;
            return 1'b0;
        end
        lowt = t - fall_stamp;
        per = t - rise_stamp;
        rise_stamp = t;
        if (!rise_seen)
        begin
            rise_seen = 1'b1;
            return 1'b0;
        end
        hight = per - lowt;
        if (hight < 1 || hight > 4302 || lowt < 1 || lowt > 4302 ||
            per < 3731 || per > 4545)
            return 1'b0;
        prod = 64'(hight) * 64'd4098;
        rd = READ_W'((prod / 64'(per)) - 64'd1);
        readings[wr_slot] = rd;
        wr_slot++;
        if (wr_slot >= RING_DEPTH)
        begin
            wr_slot = 0;
            readings_full = 1'b1;
        end
        if (!readings_full)
            return 1'b0;
        // most frequent reading, ties to the smaller value
        best = '0;
        best_n = 0;
        for (int i = 0; i < RING_DEPTH; i++)
        begin
            n = 0;
            for (int j = 0; j < RING_DEPTH; j++)
                if (readings[j] == readings[i])
                    n++;
            if (n > best_n || (n == best_n && readings[i] < best))
            begin
                best_n = n;
                best = readings[i];
            end
        end
        if (best <= 4094)
            pos = POS_W'(best);
        else if (best == 4096 || best == 4097)
            pos = 12'd4095;
        else
            return 1'b0;
        if (!pos_seeded)
        begin
            prev_pos = pos;
            pos_seeded = 1'b1;
            return 1'b0;
        end
        delta = int'(pos) - int'(prev_pos);
        if (delta > LAP_JUMP)
        begin
            laps = laps - 1;
            heading = DIR_CW;
        end
        else if (delta < -LAP_JUMP)
        begin
            laps = laps + 1;
            heading = DIR_CCW;
        end
        else if (delta > DIR_DEADBAND)
            heading = DIR_CW;
        else if (delta < -DIR_DEADBAND)
            heading = DIR_CCW;
        prev_pos = pos;
        res.position = pos;
        res.lap_count = laps;
        res.turn_direction = heading;
        res.vote_count = CNT_W'(best_n);
        return 1'b1;
    endfunction

    // drive one edge transaction; typed_res overrides the prediction when given
    task automatic send_edge(input logic lvl, input logic [31:0] t,
                             input logic typed, input result_t typed_res);
        int unsigned gap;
        result_t res;
        gap = $urandom_range(0, 11);
        if (gap > 0)
        begin
            edge_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        edge_if.valid <= 1'b1;
        edge_if.level <= lvl;
        edge_if.time_us <= t;
        do
            @(posedge clk);
        while (!edge_if.ready);
        if (decode_edge(lvl, t, res))
            pending_q.push_back(typed ? typed_res : res);
    endtask

    // one pwm frame: falling edge after the high time, rising edge after the period
    task automatic send_frame(input int unsigned h, input int unsigned p,
                              input logic typed, input result_t typed_res);
        send_edge(1'b0, t_now + h, 1'b0, '0);
        send_edge(1'b1, t_now + p, typed, typed_res);
        t_now = t_now + p;
    endtask

    task automatic wait_drained();
        edge_if.valid <= 1'b0;
        while (pending_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYC) @(posedge clk);
    endtask

    task automatic set_enable(input logic v);
        wait_drained();
        enable_we <= 1'b1;
        enable_data <= v;
        @(posedge clk);
        enable_we <= 1'b0;
        en_shadow = v;
    endtask

    // directed frames: high time, period, typed expectation
    typedef struct {
        int unsigned h;
        int unsigned p;
        logic        typed;
        result_t     res;
    } frame_row_t;

    frame_row_t frame_tbl [22];

    initial
    begin
        for (int i = 0; i < 10; i++)
            frame_tbl[i] = '{1001, 4098, 1'b0, '0};
        // ring full of 1000, first vote seeds, later votes give results
        frame_tbl[9] = '{1001, 4098, 1'b1, '{12'd1000, 32'd0, DIR_UNKNOWN, 7'd8}};
        for (int i = 10; i < 15; i++)
            frame_tbl[i] = '{4097, 4098, 1'b0, '0};
        // 4096 wins five to three, maps to top position, backward lap
        frame_tbl[14] = '{4097, 4098, 1'b1, '{12'd4095, -32'sd1, DIR_CW, 7'd5}};
        frame_tbl[15] = '{1, 4200, 1'b0, '0};      // reading below zero
        frame_tbl[16] = '{4302, 4545, 1'b0, '0};   // longest period
        frame_tbl[17] = '{1, 3731, 1'b0, '0};      // shortest period
        frame_tbl[18] = '{100, 3730, 1'b0, '0};    // period too short
        frame_tbl[19] = '{100, 4546, 1'b0, '0};    // period too long
        frame_tbl[20] = '{4098, 4098, 1'b0, '0};   // no low time
        frame_tbl[21] = '{4096, 4098, 1'b0, '0};   // reading 4095, rejected
    end

    // stimulus
    initial
    begin
        int unsigned target, p, h, burst;
        rst_n = 1'b0;
        enable_we = 1'b0;
        enable_data = 1'b0;
        edge_if.valid = 1'b0;
        edge_if.level = 1'b0;
        edge_if.time_us = '0;
        en_shadow = 1'b0;
        fall_stamp = '0;
        rise_stamp = '0;
        rise_seen = 1'b0;
        for (int i = 0; i < RING_DEPTH; i++)
            readings[i] = '0;
        wr_slot = 0;
        readings_full = 1'b0;
        prev_pos = '0;
        pos_seeded = 1'b0;
        laps = '0;
        heading = DIR_UNKNOWN;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // edges while disabled are ignored
        send_edge(1'b1, 32'hFFFF_FFFF, 1'b0, '0);
        send_edge(1'b0, 32'h0, 1'b0, '0);
        set_enable(1'b1);

        // directed table, starting near the timestamp wrap
        t_now = 32'hFFFF_E000;
        send_edge(1'b1, t_now, 1'b0, '0);
        foreach (frame_tbl[i])
            send_frame(frame_tbl[i].h, frame_tbl[i].p, frame_tbl[i].typed,
                       frame_tbl[i].res);

        // random frames, mostly steady readings with moves and noise
        t_now = $urandom;
        target = $urandom_range(0, 4096);
        for (int k = 0; k < RAND_FRAMES; k++)
        begin
            if (k == 150)
                wait_drained();
            if (k == 200)
            begin
                set_enable(1'b0);
                for (int j = 0; j < 6; j++)
                    send_edge(1'($urandom), $urandom, 1'b0, '0);
                set_enable(1'b1);
            end
            if ($urandom_range(0, 99) < 15)
            begin
                burst = $urandom_range(0, 3);
                if (burst == 0)
                    target = $urandom_range(0, 4096);
                else if (burst == 1)
                    target = $urandom_range(4090, 4096);
                else
                    target = (target + $urandom_range(0, 40) + 4077) % 4097;
            end
            if ($urandom_range(0, 99) < 8)
            begin
                // broken frame or stray edge
                send_edge(1'($urandom), $urandom_range(0, 1) ? $urandom
                          : t_now + $urandom_range(0, 5000), 1'b0, '0);
                t_now = $urandom_range(0, 1) ? t_now : $urandom;
            end
            else
            begin
                p = ($urandom_range(0, 99) < 75) ? 4098 : $urandom_range(3725, 4550);
                h = target + 1;
                if (p != 4098)
                    h = (h * p + 4097) / 4098;
                if (h >= p)
                    h = p - 1;
                send_frame(h, p, 1'b0, '0);
            end
        end

        // drain and close
        edge_if.valid <= 1'b0;
        while (pending_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYC) @(posedge clk);
        if (!failed)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    // result receiver with random stalls
    initial
    begin
        int unsigned w;
        res_if.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            w = $urandom_range(0, 11);
            if (w > 0)
            begin
                res_if.ready <= 1'b0;
                repeat (w) @(posedge clk);
            end
            while (hold_rx)
            begin
                res_if.ready <= 1'b0;
                @(posedge clk);
            end
            res_if.ready <= 1'b1;
            do
                @(posedge clk);
            while (!res_if.valid);
        end
    end

    // one long hold-off so the block backs up and stalls its input
    initial
    begin
        hold_rx = 1'b0;
        wait (results_seen == 15);
        hold_rx = 1'b1;
        repeat (HOLD_CYC) @(posedge clk);
        hold_rx = 1'b0;
    end

    // compare each result transaction with the oldest prediction
    always @(posedge clk)
    begin
        result_t want;
        if (rst_n && res_if.valid && res_if.ready)
        begin
            results_seen <= results_seen + 1;
            if (pending_q.size() == 0)
            begin
                $display("%0t: unexpected result pos %0d laps %0d dir %0d votes %0d",
                         $time, res_if.position, res_if.lap_count,
                         res_if.turn_direction, res_if.vote_count);
                failed = 1'b1;
            end
            else
            begin
                want = pending_q.pop_front();
                if (res_if.position !== want.position)
                begin
                    $display("%0t: position expected %0d actual %0d", $time,
                             want.position, res_if.position);
                    failed = 1'b1;
                end
                if (res_if.lap_count !== want.lap_count)
                begin
                    $display("%0t: lap_count expected %0d actual %0d", $time,
                             $signed(want.lap_count), res_if.lap_count);
                    failed = 1'b1;
                end
                if (res_if.turn_direction !== want.turn_direction)
                begin
                    $display("%0t: turn_direction expected %0d actual %0d", $time,
                             want.turn_direction, res_if.turn_direction);
                    failed = 1'b1;
                end
                if (res_if.vote_count !== want.vote_count)
                begin
                    $display("%0t: vote_count expected %0d actual %0d", $time,
                             want.vote_count, res_if.vote_count);
                    failed = 1'b1;
                end
            end
        end
    end

    // watchdog
    initial
    begin
        #20_000_000;
        $display("timeout with %0d results outstanding", pending_q.size());
        $display("== FAIL ==");
        $finish;
    end
endmodule
